// ----- rtl/nmc_pkg.sv -----
// Shared types, codes and reset constants of the navigation momentum classifier.
package nmc_pkg;

  localparam int PAGE_BITS_DEF = 20;
  localparam int PAGE_IN_W     = 21;
  localparam int TIME_W        = 40;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int RUN_W         = 8;
  localparam int MODE_W        = 3;

  localparam logic [RUN_W-1:0] RUN_MAX       = 8'd255;
  localparam logic [RUN_W-1:0] RUN_THRESHOLD = 8'd2;

  localparam logic [CFG_W-1:0] BIASED_WINDOW_RST  = 16'd450;
  localparam logic [CFG_W-1:0] SCRUB_WINDOW_RST   = 16'd120;
  localparam logic [CFG_W-1:0] NEUTRAL_WINDOW_RST = 16'd800;
  localparam logic [CFG_W-1:0] SCRUB_JUMP_RST     = 16'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_NEUTRAL     = 3'd0,
    MODE_NEXT_BIASED = 3'd1,
    MODE_PREV_BIASED = 3'd2,
    MODE_SCRUB_NEXT  = 3'd3,
    MODE_SCRUB_PREV  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_NEXT = 2'd1,
    DIR_PREV = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIASED_WINDOW  = 8'd0,
    CFG_SCRUB_WINDOW   = 8'd1,
    CFG_NEUTRAL_WINDOW = 8'd2,
    CFG_SCRUB_JUMP     = 8'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] biased_window;
    logic [CFG_W-1:0] scrub_window;
    logic [CFG_W-1:0] neutral_window;
    logic [CFG_W-1:0] scrub_jump;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic [RUN_W-1:0] runs;
  } result_t;

endpackage

// ----- rtl/navigation_momentum_classifier_top.sv -----
// Top level of the navigation momentum classifier: stream ports, config registers, pipeline.
// Each word passes through the input register and then the result register to out_tdata.
// Throughput: one word per cycle while results are taken; classification is combinational.
// The input register and the result register each advance whenever the result side can take.
// Reset (rst_n, synchronous, active low) empties both stages, clears the page/time history
// and loads the window registers with their defaults; no clearing pass is needed.
module navigation_momentum_classifier_top import nmc_pkg::*; #(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [20:0] page_number, [60:21] event_time_ms, rest 0
  // Result stream.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // [2:0] momentum_mode, [10:3] run_length, rest 0
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg_r;

  logic                 s1_valid_r;
  logic [PAGE_IN_W-1:0] s1_page_r;
  logic [TIME_W-1:0]    s1_time_r;

  logic                 out_valid_r;
  result_t              out_res_r;

  logic                 advance;
  logic                 step;
  result_t              result;

  // Always writable; the user must write only while the block is idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.biased_window  <= BIASED_WINDOW_RST;
      cfg_r.scrub_window   <= SCRUB_WINDOW_RST;
      cfg_r.neutral_window <= NEUTRAL_WINDOW_RST;
      cfg_r.scrub_jump     <= SCRUB_JUMP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIASED_WINDOW:  cfg_r.biased_window  <= cfg_data;
        CFG_SCRUB_WINDOW:   cfg_r.scrub_window   <= cfg_data;
        CFG_NEUTRAL_WINDOW: cfg_r.neutral_window <= cfg_data;
        CFG_SCRUB_JUMP:     cfg_r.scrub_jump     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result register frees up when it is empty or is being taken this cycle.
  // The input register then hands its word on, and so can take a new one.
  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_page_r <= in_tdata[PAGE_IN_W-1:0];
      s1_time_r <= in_tdata[PAGE_IN_W+TIME_W-1:PAGE_IN_W];
    end
  end

  // History state is updated on the same edge that loads the result register, so the
  // next word in the input register always sees the history left by this one.
  nmc_core #(
    .PAGE_BITS (PAGE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .page_in (s1_page_r),
    .time_in (s1_time_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.runs, out_res_r.mode};

endmodule

// ----- rtl/nmc_core.sv -----
// History state and move classification of the navigation momentum classifier.
module nmc_core import nmc_pkg::*; #(
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [PAGE_IN_W-1:0] page_in,
  input  logic [TIME_W-1:0]    time_in,
  input  cfg_t                 cfg,
  output result_t              result
);

  localparam int JUMP_W = (PAGE_BITS > CFG_W) ? PAGE_BITS : CFG_W;

  logic                  have_last_r;
  logic [PAGE_BITS-1:0]  last_page_r;
  logic [TIME_W-1:0]     last_time_r;
  dir_t                  last_dir_r;
  logic [RUN_W-1:0]      runs_r;

  logic                        no_page;
  logic [PAGE_BITS+19:0]       page_ext;
  logic [PAGE_BITS-1:0]        page;
  logic [TIME_W:0]             elapsed;
  logic                        in_biased;
  logic                        in_scrub;
  logic                        in_active;
  logic                        is_next;
  dir_t                        dir;
  logic [PAGE_BITS-1:0]        jump;
  logic                        jump_big;
  logic [RUN_W-1:0]            runs_inc;
  logic [RUN_W-1:0]            runs_new;
  logic                        run;
  logic                        scrub;
  logic                        moving;
  logic                        first;

  // The page is taken modulo 2^PAGE_BITS; wider page storage sees zeros on top.
  assign no_page  = page_in[PAGE_IN_W-1];
  assign page_ext = {{PAGE_BITS{1'b0}}, page_in[19:0]};
  assign page     = page_ext[PAGE_BITS-1:0];

  // Exact signed difference; the top bit is the sign.
  assign elapsed   = {1'b0, time_in} - {1'b0, last_time_r};
  assign in_biased = elapsed[TIME_W] || (elapsed[TIME_W-1:0] <= TIME_W'(cfg.biased_window));
  assign in_scrub  = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] <= TIME_W'(cfg.scrub_window));
  assign in_active = !elapsed[TIME_W] && (elapsed[TIME_W-1:0] < TIME_W'(cfg.neutral_window));

  assign is_next  = page > last_page_r;
  assign dir      = is_next ? DIR_NEXT : DIR_PREV;
  assign jump     = is_next ? (page - last_page_r) : (last_page_r - page);
  assign jump_big = JUMP_W'(jump) >= JUMP_W'(cfg.scrub_jump);

  assign runs_inc = (runs_r == RUN_MAX) ? RUN_MAX : runs_r + 8'd1;
  assign runs_new = ((dir == last_dir_r) && in_biased) ? runs_inc : 8'd1;
  assign run      = runs_new >= RUN_THRESHOLD;
  assign scrub    = (run && in_scrub) || (jump_big && in_biased);

  assign first  = !no_page && !have_last_r;
  assign moving = !no_page && have_last_r && (page != last_page_r);

  always_comb begin
    result.mode = MODE_NEUTRAL;
    result.runs = runs_r;
    if (moving) begin
      result.runs = runs_new;
      if (in_active) begin
        if (scrub) begin
          result.mode = is_next ? MODE_SCRUB_NEXT : MODE_SCRUB_PREV;
        end else if (run && in_biased) begin
          result.mode = is_next ? MODE_NEXT_BIASED : MODE_PREV_BIASED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
      last_page_r <= '0;
      last_time_r <= '0;
      last_dir_r  <= DIR_NONE;
      runs_r      <= '0;
    end else if (step) begin
      if (first) begin
        have_last_r <= 1'b1;
        last_page_r <= page;
        last_time_r <= time_in;
      end
      if (moving) begin
        last_page_r <= page;
        last_time_r <= time_in;
        last_dir_r  <= dir;
        runs_r      <= runs_new;
      end
    end
  end

endmodule

// ----- dv/tb_navigation_momentum_classifier_top.sv -----
// Self-checking testbench of the navigation momentum classifier with its scoreboard.
`timescale 1ns / 1ps

module tb_navigation_momentum_classifier_top import nmc_pkg::*; ;

  // The block is built with its default page width, so the page index is the low
  // PG_W bits of the signed page field and the field's top bit means "no page".
  localparam int PG_W        = PAGE_BITS_DEF;
  localparam int PAGE_MAX    = (1 << PG_W) - 1;
  localparam int CFG_SLOTS   = 4;       // Indexes at and above this hit no register.
  localparam int IDX_TOP     = (1 << CFG_IDX_W) - 1;
  localparam int SEGMENTS    = 6;
  localparam int SEG_ITEMS   = 172;
  localparam int WATCHDOG_NS = 2_000_000;

  // The scoreboard holds a private copy of the history registers and the window
  // settings. Every accepted input word is classified at once and its expected
  // result is queued; result words are matched against the oldest entry.
  class momentum_scoreboard;
    logic [CFG_W-1:0]  biased_win;
    logic [CFG_W-1:0]  scrub_win;
    logic [CFG_W-1:0]  neutral_win;
    logic [CFG_W-1:0]  jump_pages;
    bit                have_last;
    logic [PG_W-1:0]   last_page;
    logic [TIME_W-1:0] last_time;
    dir_t              last_dir;
    logic [RUN_W-1:0]  runs;
    result_t           expected_q[$];
    int                errors;
    int                checked;
    int                mode_hits[5];

    function new();
      biased_win  = BIASED_WINDOW_RST;
      scrub_win   = SCRUB_WINDOW_RST;
      neutral_win = NEUTRAL_WINDOW_RST;
      jump_pages  = SCRUB_JUMP_RST;
      have_last   = 1'b0;
      last_page   = '0;
      last_time   = '0;
      last_dir    = DIR_NONE;
      runs        = '0;
      errors      = 0;
      checked     = 0;
      foreach (mode_hits[m]) mode_hits[m] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_BIASED_WINDOW:  biased_win  = val;
        CFG_SCRUB_WINDOW:   scrub_win   = val;
        CFG_NEUTRAL_WINDOW: neutral_win = val;
        CFG_SCRUB_JUMP:     jump_pages  = val;
        default: ;
      endcase
    endfunction

    function void note_event(logic [63:0] word);
      logic [PAGE_IN_W-1:0] page_field;
      logic [TIME_W-1:0]    now;
      logic [PG_W-1:0]      page;
      logic [PG_W-1:0]      jump;
      longint               elapsed;
      bit                   going_next;
      bit                   in_biased;
      bit                   in_run;
      bit                   scrub;
      dir_t                 dir;
      mode_t                mode;
      result_t              exp;
      page_field = word[PAGE_IN_W-1:0];
      now        = word[PAGE_IN_W +: TIME_W];
      mode       = MODE_NEUTRAL;
      if (!page_field[PAGE_IN_W-1]) begin
        page = page_field[PG_W-1:0];
        if (!have_last) begin
          have_last = 1'b1;
          last_page = page;
          last_time = now;
        end else if (page != last_page) begin
          elapsed    = longint'({24'd0, now}) - longint'({24'd0, last_time});
          going_next = page > last_page;
          dir        = going_next ? DIR_NEXT : DIR_PREV;
          jump       = going_next ? page - last_page : last_page - page;
          in_biased  = elapsed <= longint'({48'd0, biased_win});
          if (dir == last_dir && in_biased)
            runs = (runs == RUN_MAX) ? RUN_MAX : runs + 1'b1;
          else
            runs = RUN_W'(1);
          if (elapsed >= 0 && elapsed < longint'({48'd0, neutral_win})) begin
            in_run = runs >= RUN_THRESHOLD;
            scrub  = (in_run && elapsed <= longint'({48'd0, scrub_win}))
                     || (jump >= PG_W'(jump_pages) && in_biased);
            if (scrub)
              mode = going_next ? MODE_SCRUB_NEXT : MODE_SCRUB_PREV;
            else if (in_run && in_biased)
              mode = going_next ? MODE_NEXT_BIASED : MODE_PREV_BIASED;
          end
          last_dir  = dir;
          last_page = page;
          last_time = now;
        end
      end
      exp.mode = mode;
      exp.runs = runs;
      expected_q.insert(expected_q.size(), exp);
      mode_hits[int'(mode)]++;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [15:0] word);
      result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word %h arrived with nothing expected", word));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (word[MODE_W-1:0] !== exp.mode)
        report_mismatch($sformatf("mode %0d, expected %0d (word %0d)",
                                  word[MODE_W-1:0], exp.mode, checked));
      if (word[MODE_W +: RUN_W] !== exp.runs)
        report_mismatch($sformatf("run length %0d, expected %0d (word %0d)",
                                  word[MODE_W +: RUN_W], exp.runs, checked));
      if (word[15:MODE_W+RUN_W] !== '0)
        report_mismatch($sformatf("padding bits %b are not zero (word %0d)",
                                  word[15:MODE_W+RUN_W], checked));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // Every input of the block starts at a known value; reset is held from time zero.
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata   = '0;   // [20:0] page_number, [60:21] event_time_ms
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;         // [2:0] momentum_mode, [10:3] run_length
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  momentum_scoreboard sb = new();

  int                   send_idle_pct = 35;
  int                   recv_idle_pct = 72;
  int                   items_sent    = 0;
  int                   cfg_writes    = 0;
  int                   cur_page      = 0;
  logic [TIME_W-1:0]    cur_time      = '0;

  navigation_momentum_classifier_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver drops tready at random; a zero percentage gives a steady stream.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both handshakes are sampled at the clock edge, before any driver update of
  // that edge lands, so each word is seen exactly once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_event(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Time steps are drawn around the current window settings so that the
  // boundaries of every window are hit, with rare long or huge steps.
  function automatic logic [31:0] pick_dt();
    logic [31:0] dt;
    logic [31:0] base;
    case ($urandom_range(9))
      0:       dt = '0;
      1, 2:    dt = $urandom_range(32'(sb.scrub_win) + 3);
      3, 4, 5: dt = $urandom_range(32'(sb.biased_win) + 3);
      6:       dt = $urandom_range(32'(sb.neutral_win) + 3);
      7: begin
        case ($urandom_range(2))
          0:       base = 32'(sb.scrub_win);
          1:       base = 32'(sb.biased_win);
          default: base = 32'(sb.neutral_win);
        endcase
        dt = (base == 0) ? $urandom_range(1) : base - 1 + $urandom_range(2);
      end
      8:       dt = $urandom_range(100000);
      default: dt = $urandom();
    endcase
    return dt;
  endfunction

  // The sender idles for a random number of cycles, then offers one word and
  // holds it until it is taken. Valid stays high between back-to-back words.
  task automatic send_event(input logic [PAGE_IN_W-1:0] page_field,
                            input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'd0, t, page_field};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Registers are only written with the pipeline empty: the sender pauses and every
  // expected result drains before the task returns.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic write_stray();
    write_register(CFG_IDX_W'($urandom_range(IDX_TOP, CFG_SLOTS)), CFG_W'($urandom()));
  endtask

  task automatic write_windows(input logic [CFG_W-1:0] biased, input logic [CFG_W-1:0] scrub,
                               input logic [CFG_W-1:0] neutral, input logic [CFG_W-1:0] jump);
    write_register(CFG_BIASED_WINDOW, biased);
    write_register(CFG_SCRUB_WINDOW, scrub);
    write_register(CFG_NEUTRAL_WINDOW, neutral);
    write_register(CFG_SCRUB_JUMP, jump);
  endtask

  // A run of moves in one direction, flipping only at the ends of the page
  // range. With tight set, every step stays inside the biased window so the
  // run count climbs all the way to saturation.
  task automatic send_run(input int len, input bit tight);
    int          dir;
    int          step;
    int          next_page;
    logic [31:0] dt;
    dir = $urandom_range(1) ? 1 : -1;
    for (int k = 0; k < len; k++) begin
      step = ($urandom_range(3) != 0) ? int'($urandom_range(4, 1))
                                      : int'($urandom_range(3000, 1));
      next_page = cur_page + dir * step;
      if (next_page < 0 || next_page > PAGE_MAX) begin
        dir       = -dir;
        next_page = cur_page + dir * step;
      end
      dt        = tight ? $urandom_range(32'(sb.biased_win)) : pick_dt();
      cur_page  = next_page;
      cur_time  = cur_time + TIME_W'(dt);
      send_event(PAGE_IN_W'(cur_page), cur_time);
    end
  endtask

  // Mostly well-formed runs; the rest are random words, repeats of the same
  // page, words with no page and steps back in time.
  task automatic send_burst();
    int                   pick;
    logic [PAGE_IN_W-1:0] field;
    pick = $urandom_range(99);
    if (pick < 65) begin
      send_run(($urandom_range(299) == 0) ? int'($urandom_range(300, 256))
                                          : int'($urandom_range(16, 1)), 1'b0);
    end else if (pick < 78) begin
      field = PAGE_IN_W'($urandom());
      if ($urandom_range(1)) cur_time = TIME_W'({$urandom(), $urandom()});
      else cur_time = cur_time + TIME_W'(pick_dt());
      if (!field[PAGE_IN_W-1]) cur_page = int'(field[PG_W-1:0]);
      send_event(field, cur_time);
    end else if (pick < 88) begin
      cur_time = cur_time + TIME_W'(pick_dt());
      send_event(PAGE_IN_W'(cur_page), cur_time);
    end else if (pick < 94) begin
      field    = $urandom_range(1) ? '1 : {1'b1, PG_W'($urandom())};
      cur_time = cur_time + TIME_W'(pick_dt());
      send_event(field, cur_time);
    end else begin
      cur_time = cur_time - TIME_W'($urandom_range(600, 1));
      cur_page = (cur_page == 0) ? 1 : cur_page - 1;
      send_event(PAGE_IN_W'(cur_page), cur_time);
    end
  endtask

  // Directed words at the reset settings: no page at both ends of the negative
  // range, the first event, a repeated page, a run building from scrubbing to
  // biased, the biased and neutral window edges, a big jump, time running
  // backwards, both page extremes and both timestamp extremes.
  task automatic send_directed();
    send_event(21'h1FFFFF, 40'd0);
    send_event(21'h100000, 40'hFF_FFFF_FFFF);
    send_event(21'd0, 40'd1000);
    send_event(21'd0, 40'd1010);
    send_event(21'd1, 40'd1050);
    send_event(21'd2, 40'd1100);
    send_event(21'd3, 40'd1400);
    send_event(21'd4, 40'd1850);
    send_event(21'd5, 40'd2301);
    send_event(21'd10, 40'd2400);
    send_event(21'd7, 40'd2450);
    send_event(21'd6, 40'd3250);
    send_event(21'd5, 40'd3200);
    send_event(21'h0FFFFF, 40'd3250);
    send_event(21'd0, 40'd3260);
    send_event(21'd1, 40'hFF_FFFF_FFFF);
    send_event(21'd0, 40'd0);
    send_event(21'h1FFFFF, 40'd5);
    send_event(21'h0AAAAA, 40'd10);
    send_event(21'h055555, 40'd20);
    send_event(21'h155555, 40'h55_5555_5555);
    cur_page = 'h55555;
    cur_time = 40'd30;
  endtask

  // Each random segment starts from an empty pipeline with new settings:
  // the defaults, all zeros, all ones, random narrow windows, a narrow band
  // with a jump of one, and random again. Stray indexes must change nothing.
  task automatic apply_setting(input int seg);
    drain();
    case (seg)
      0: begin
        write_windows(BIASED_WINDOW_RST, SCRUB_WINDOW_RST, NEUTRAL_WINDOW_RST, SCRUB_JUMP_RST);
        write_stray();
      end
      1: write_windows('0, '0, '0, '0);
      2: write_windows('1, '1, '1, '1);
      3: begin
        write_windows(CFG_W'($urandom_range(600, 50)), CFG_W'($urandom_range(200)),
                      CFG_W'($urandom_range(1000, 100)), CFG_W'($urandom_range(8, 1)));
        write_stray();
      end
      4: write_windows(CFG_W'(300), CFG_W'(300), CFG_W'(301), CFG_W'(1));
      default: write_windows(CFG_W'($urandom_range(1000)), CFG_W'($urandom_range(400)),
                             CFG_W'($urandom_range(1500)), CFG_W'($urandom_range(16, 1)));
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // Idle pattern: receiver-heavy gaps first, then sender-heavy, then none.
      if (seg == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 35;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting(seg);
      if (seg == 0) send_run(280, 1'b1);
      while (items_sent < 21 + (seg + 1) * SEG_ITEMS) send_burst();
    end
    drain();
    repeat (5) @(posedge clk);
    $display("summary: %0d events, %0d results checked, %0d register writes, %0d mismatches",
             items_sent, sb.checked, cfg_writes, sb.errors);
    $display("summary: neutral %0d, next biased %0d, prev biased %0d, scrub next %0d, %s %0d",
             sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3],
             "scrub prev", sb.mode_hits[4]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this time.
  initial begin
    #(WATCHDOG_NS);
    $display("timeout with %0d results still expected", sb.pending());
    $display("tb: failure");
    $finish;
  end

endmodule
